[src/ktpt_pkg.sv]
// Shared types, codes and microprogram for the k-ary tree position tracker.
package ktpt_pkg;

    localparam int LAYER_BITS = 6;
    localparam int FANOUT_BITS = 8;
    localparam int FIELD_BITS = 32;
    localparam logic [LAYER_BITS-1:0] LAYER_MAX = 6'd63;
    localparam logic [FANOUT_BITS-1:0] FANOUT_RESET = 8'd2;
    localparam logic [FANOUT_BITS-1:0] FANOUT_MIN = 8'd2;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_INC   = 2'd1,
        MODE_DEC   = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        UOP_WAIT,
        UOP_STEP,
        UOP_APPLY,
        UOP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_REQ,
        COND_MORE,
        COND_OUT_FREE
    } t_cond;

    typedef logic [1:0] t_step;

    localparam t_step STEP_IDLE  = 2'd0;
    localparam t_step STEP_WALK  = 2'd1;
    localparam t_step STEP_APPLY = 2'd2;
    localparam t_step STEP_EMIT  = 2'd3;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step jmp_t;
        t_step jmp_f;
    } t_ctrl;

    typedef struct packed {
        logic take;
        t_uop op;
    } t_dp_ctrl;

    typedef struct packed {
        logic more;
    } t_dp_stat;

    typedef struct packed {
        logic [LAYER_BITS-1:0] layer;
        logic [FIELD_BITS-1:0] offset;
        logic [FIELD_BITS-1:0] index;
    } t_result;

    function automatic t_ctrl ktpt_rom(input t_step step);
        t_ctrl word;
        unique case (step)
            STEP_IDLE:  word = '{op: UOP_WAIT,  cond: COND_REQ,
                                 jmp_t: STEP_WALK,  jmp_f: STEP_IDLE};
            STEP_WALK:  word = '{op: UOP_STEP,  cond: COND_MORE,
                                 jmp_t: STEP_WALK,  jmp_f: STEP_APPLY};
            STEP_APPLY: word = '{op: UOP_APPLY, cond: COND_ALWAYS,
                                 jmp_t: STEP_EMIT,  jmp_f: STEP_EMIT};
            STEP_EMIT:  word = '{op: UOP_EMIT,  cond: COND_OUT_FREE,
                                 jmp_t: STEP_IDLE,  jmp_f: STEP_EMIT};
            default:    word = '{op: UOP_WAIT,  cond: COND_ALWAYS,
                                 jmp_t: STEP_IDLE,  jmp_f: STEP_IDLE};
        endcase
        return word;
    endfunction

endpackage

[src/ktpt_datapath.sv]
// Layer walk datapath: position state, layer size and prefix sum registers.
module ktpt_datapath #(
    parameter int POS_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ktpt_pkg::FANOUT_BITS-1:0] i_cfg_data,
    input  ktpt_pkg::t_dp_ctrl            i_ctrl,
    input  logic [1:0]                    i_mode,
    input  logic [ktpt_pkg::FIELD_BITS-1:0] i_linear_pos,
    output ktpt_pkg::t_dp_stat            o_stat,
    output ktpt_pkg::t_result             o_result
);
    import ktpt_pkg::*;

    localparam int P  = POS_BITS;
    localparam int NW = POS_BITS + 1;
    localparam int SW = NW + 1;
    localparam int MW = NW + FANOUT_BITS;
    localparam logic [P-1:0]  POS_MAX = {P{1'b1}};
    localparam logic [NW-1:0] SIZE_CAP = (POS_BITS >= 64) ? NW'({P{1'b1}})
                                                          : (NW'(1) << POS_BITS);

    logic [FANOUT_BITS-1:0] r_fanout;
    logic [LAYER_BITS-1:0]  r_layer;
    logic [P-1:0]           r_off;
    t_mode                  r_mode;
    logic [P-1:0]           r_p;
    logic [P-1:0]           r_pre;
    logic [NW-1:0]          r_n;
    logic [LAYER_BITS-1:0]  r_cnt;
    logic [LAYER_BITS-1:0]  r_tgt;

    logic [FANOUT_BITS-1:0] w_k;
    logic [MW-1:0]          w_prod;
    logic [NW-1:0]          w_grow;
    logic [P-1:0]           w_pre_n;
    logic [P-1:0]           w_sum;
    logic [P-1:0]           w_pin;
    logic                   w_more;
    logic                   w_step_en;
    logic                   w_apply_en;
    logic                   w_at_end;
    logic                   w_inc_hold;
    logic                   w_up_layer;

    function automatic logic [P-1:0] add_sat(input logic [P-1:0] a,
                                             input logic [NW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        return (s > SW'(POS_MAX)) ? POS_MAX : s[P-1:0];
    endfunction

    assign w_k     = (r_fanout < FANOUT_MIN) ? FANOUT_MIN : r_fanout;
    assign w_prod  = MW'(r_n) * MW'(w_k);
    assign w_grow  = (w_prod > MW'(SIZE_CAP)) ? SIZE_CAP : w_prod[NW-1:0];
    assign w_pre_n = add_sat(r_pre, r_n);
    assign w_sum   = add_sat(r_pre, NW'(r_off));
    assign w_pin   = P'(i_linear_pos);

    always_comb begin
        if (r_mode == MODE_LOAD) begin
            w_more = (NW'(r_p) > r_n) && (r_cnt < LAYER_MAX);
        end else begin
            w_more = r_cnt < r_tgt;
        end
    end

    assign w_step_en  = (i_ctrl.op == UOP_STEP) && w_more;
    assign w_apply_en = i_ctrl.op == UOP_APPLY;
    assign w_at_end   = NW'(r_off) == (r_n - NW'(1));
    assign w_inc_hold = (w_sum == POS_MAX) || (w_at_end && (r_layer == LAYER_MAX));
    assign w_up_layer = !w_inc_hold && w_at_end;

    assign o_stat.more      = w_more;
    assign o_result.layer   = r_layer;
    assign o_result.offset  = FIELD_BITS'(r_off);
    assign o_result.index   = FIELD_BITS'(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fanout <= FANOUT_RESET;
            r_layer  <= '0;
            r_off    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fanout <= i_cfg_data;
            end
            if (w_apply_en) begin
                unique case (r_mode)
                    MODE_LOAD: begin
                        r_layer <= r_cnt;
                        r_off   <= r_p - P'(1);
                    end
                    MODE_INC: begin
                        if (w_up_layer) begin
                            r_layer <= r_layer + LAYER_BITS'(1);
                            r_off   <= '0;
                        end else if (!w_inc_hold) begin
                            r_off <= r_off + P'(1);
                        end
                    end
                    MODE_DEC: begin
                        if (r_off != '0) begin
                            r_off <= r_off - P'(1);
                        end else if (r_layer != '0) begin
                            r_layer <= r_layer - LAYER_BITS'(1);
                            r_off   <= r_n[P-1:0] - P'(1);
                        end
                    end
                    MODE_QUERY: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_mode <= t_mode'(i_mode);
            r_p    <= (w_pin == '0) ? P'(1) : w_pin;
            r_pre  <= '0;
            r_n    <= NW'(1);
            r_cnt  <= '0;
            if ((i_mode == MODE_DEC) && (r_off == '0) && (r_layer != '0)) begin
                r_tgt <= r_layer - LAYER_BITS'(1);
            end else begin
                r_tgt <= r_layer;
            end
        end else if (w_step_en) begin
            r_pre <= w_pre_n;
            r_n   <= w_grow;
            r_cnt <= r_cnt + LAYER_BITS'(1);
            if (r_mode == MODE_LOAD) begin
                r_p <= r_p - r_n[P-1:0];
            end
        end else if (w_apply_en && (r_mode == MODE_INC) && w_up_layer) begin
            r_pre <= w_pre_n;
        end
    end

endmodule

[src/kary_tree_position_tracker.sv]
// Top level of the k-ary tree position tracker: microcode sequencer and result register.
//
// Input channel (i_in_valid / o_in_ready) carries one request: i_mode and
// i_linear_pos. Mode load splits a 1-based level-order position into layer and
// offset, increment and decrement step through level order, query reports only.
// Output channel (o_out_valid / i_out_ready) carries one result per request:
// o_layer, o_offset and the 0-based level-order index o_index.
// i_cfg_we writes the fanout from i_cfg_data; write it only while idle.
// A request walks the tree one layer per cycle through one multiplier up to a
// layer L: the loaded layer for a load, the new layer for a decrement that
// crosses a layer start, else the current layer. After the walk an update step
// moves the node and a result step loads the output register; the next request
// is accepted only after that.
// The result sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, a second result holds in the sequencer and no
// further request is accepted until the first one is taken.
// Reset puts the node at the root and sets the fanout to 2; no result is pending.
module kary_tree_position_tracker #(
    parameter int POS_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ktpt_pkg::FANOUT_BITS-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_mode,
    input  logic [ktpt_pkg::FIELD_BITS-1:0]  i_linear_pos,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ktpt_pkg::LAYER_BITS-1:0]  o_layer,
    output logic [ktpt_pkg::FIELD_BITS-1:0]  o_offset,
    output logic [ktpt_pkg::FIELD_BITS-1:0]  o_index
);
    import ktpt_pkg::*;

    t_step    r_step;
    t_step    n_step;
    logic     r_out_valid;
    t_result  r_result;
    t_ctrl    w_ctrl;
    t_dp_ctrl w_dp_ctrl;
    t_dp_stat w_dp_stat;
    t_result  w_result;
    logic     w_take;
    logic     w_out_free;
    logic     w_cond;

    assign w_ctrl     = ktpt_rom(r_step);
    assign o_in_ready = w_ctrl.op == UOP_WAIT;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (w_ctrl.cond)
            COND_ALWAYS:   w_cond = 1'b1;
            COND_REQ:      w_cond = w_take;
            COND_MORE:     w_cond = w_dp_stat.more;
            COND_OUT_FREE: w_cond = w_out_free;
            default:       w_cond = 1'b1;
        endcase
        n_step = w_cond ? w_ctrl.jmp_t : w_ctrl.jmp_f;
    end

    assign w_dp_ctrl.take = w_take;
    assign w_dp_ctrl.op   = w_ctrl.op;

    ktpt_datapath #(
        .POS_BITS (POS_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_ctrl       (w_dp_ctrl),
        .i_mode       (i_mode),
        .i_linear_pos (i_linear_pos),
        .o_stat       (w_dp_stat),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if ((w_ctrl.op == UOP_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_ctrl.op == UOP_EMIT) && w_out_free) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_layer     = r_result.layer;
    assign o_offset    = r_result.offset;
    assign o_index     = r_result.index;

endmodule

[test/ktpt_position_checker.sv]
// Checker for the k-ary tree position tracker: predicts each result and compares it.
module ktpt_position_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ktpt_pkg::FANOUT_BITS-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic [ktpt_pkg::FIELD_BITS-1:0] i_linear_pos,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [ktpt_pkg::LAYER_BITS-1:0] o_layer,
    input  logic [ktpt_pkg::FIELD_BITS-1:0] o_offset,
    input  logic [ktpt_pkg::FIELD_BITS-1:0] o_index,
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import ktpt_pkg::*;

    localparam logic [63:0] POS_LIMIT  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] SIZE_LIMIT = 64'h0000_0001_0000_0000;

    logic [FANOUT_BITS-1:0] tree_fanout;
    logic [LAYER_BITS-1:0]  node_layer;
    logic [FIELD_BITS-1:0]  node_offset;
    t_result                expected_nodes[$];

    function automatic logic [63:0] times_fanout(input logic [63:0] n, input logic [63:0] k);
        if (n > SIZE_LIMIT / k) begin
            return SIZE_LIMIT;
        end
        return (n * k > SIZE_LIMIT) ? SIZE_LIMIT : n * k;
    endfunction

    function automatic logic [63:0] sum_capped(input logic [63:0] a, input logic [63:0] b);
        if (a > POS_LIMIT || b > POS_LIMIT - a) begin
            return POS_LIMIT;
        end
        return a + b;
    endfunction

    function automatic logic [63:0] layer_width(input logic [LAYER_BITS-1:0] layer,
                                                input logic [63:0] k);
        logic [63:0] n;
        n = 64'd1;
        for (int l = 0; l < layer && n < SIZE_LIMIT; l++) begin
            n = times_fanout(n, k);
        end
        return n;
    endfunction

    function automatic logic [63:0] node_index(input logic [LAYER_BITS-1:0] layer,
                                               input logic [FIELD_BITS-1:0] offset,
                                               input logic [63:0] k);
        logic [63:0] first;
        logic [63:0] n;
        first = 64'd0;
        n = 64'd1;
        for (int l = 0; l < layer; l++) begin
            first = sum_capped(first, n);
            n = times_fanout(n, k);
        end
        return sum_capped(first, {32'b0, offset});
    endfunction

    function automatic void advance_node(input t_mode mode, input logic [FIELD_BITS-1:0] pos,
                                         input logic [63:0] k);
        logic [63:0]           p;
        logic [63:0]           n;
        logic [LAYER_BITS-1:0] l;
        case (mode)
            MODE_LOAD: begin
                p = (pos == '0) ? 64'd1 : {32'b0, pos};
                n = 64'd1;
                l = '0;
                while (p > n && l < LAYER_MAX) begin
                    p = p - n;
                    l = l + 1'b1;
                    n = times_fanout(n, k);
                end
                p = p - 64'd1;
                node_layer = l;
                node_offset = p[FIELD_BITS-1:0];
            end
            MODE_INC: begin
                if (node_index(node_layer, node_offset, k) < POS_LIMIT) begin
                    if ({32'b0, node_offset} == layer_width(node_layer, k) - 64'd1) begin
                        if (node_layer < LAYER_MAX) begin
                            node_layer = node_layer + 1'b1;
                            node_offset = '0;
                        end
                    end else begin
                        node_offset = node_offset + 1'b1;
                    end
                end
            end
            MODE_DEC: begin
                if (node_offset == '0 && node_layer != '0) begin
                    node_layer = node_layer - 1'b1;
                    n = layer_width(node_layer, k) - 64'd1;
                    node_offset = n[FIELD_BITS-1:0];
                end else if (node_offset != '0) begin
                    node_offset = node_offset - 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_result     seen;
        t_result     want;
        logic [63:0] k;
        logic [63:0] idx;
        if (!i_rst_n) begin
            tree_fanout = FANOUT_RESET;
            node_layer = '0;
            node_offset = '0;
            expected_nodes.delete();
            o_mismatches = 0;
            o_results = 0;
        end else begin
            if (i_cfg_we) begin
                tree_fanout = i_cfg_data;
            end
            if (o_out_valid && i_out_ready) begin
                seen = '{layer: o_layer, offset: o_offset, index: o_index};
                o_results++;
                if (expected_nodes.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("%0t: unexpected result layer %0d offset %0d index %0d",
                                 $realtime, o_layer, o_offset, o_index);
                    end
                end else begin
                    want = expected_nodes.pop_front();
                    if (seen.layer !== want.layer || seen.offset !== want.offset ||
                        seen.index !== want.index) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: result %0d expected layer %0d offset %0d index %0d",
                                     $realtime, o_results, want.layer, want.offset, want.index);
                            $display("%0t: result %0d actual   layer %0d offset %0d index %0d",
                                     $realtime, o_results, seen.layer, seen.offset, seen.index);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                k = (tree_fanout < FANOUT_MIN) ? {56'b0, FANOUT_MIN} : {56'b0, tree_fanout};
                advance_node(t_mode'(i_mode), i_linear_pos, k);
                idx = node_index(node_layer, node_offset, k);
                expected_nodes.push_back('{layer: node_layer, offset: node_offset,
                                           index: idx[FIELD_BITS-1:0]});
            end
        end
        o_pending = expected_nodes.size();
    end

endmodule

[test/kary_tree_position_tracker_test.sv]
// Testbench top for the k-ary tree position tracker: stimulus, fanout phases and verdict.
module kary_tree_position_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ktpt_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [FANOUT_BITS-1:0] i_cfg_data = FANOUT_RESET;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_mode = MODE_QUERY;
    logic [FIELD_BITS-1:0]  i_linear_pos = 32'd1;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [LAYER_BITS-1:0]  o_layer;
    logic [FIELD_BITS-1:0]  o_offset;
    logic [FIELD_BITS-1:0]  o_index;

    int o_mismatches;
    int o_pending;
    int o_results;

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int requests_sent = 0;
    int fanout_now = FANOUT_RESET;
    int fanout_plan[8] = '{255, 3, 0, 16, 1, 200, 7, 2};

    kary_tree_position_tracker uut (.*);

    ktpt_position_checker u_checker (.*);

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #4ms;
        $display("kary_tree_position_tracker verification failed");
        $finish;
    end

    task automatic send_request(input t_mode mode, input logic [FIELD_BITS-1:0] pos);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_mode = mode;
        i_linear_pos = pos;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (o_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (40) @(negedge i_clk);
    endtask

    task automatic walk_tree(input int count);
        int          sent;
        int          steps;
        int          pick;
        logic        upward;
        logic [63:0] first_pos;
        logic [63:0] width;
        logic [63:0] eff;
        logic [31:0] pos;
        sent = 0;
        eff = (fanout_now < 2) ? 64'd2 : 64'(fanout_now);
        while (sent < count) begin
            if ($urandom_range(9) < 8) begin
                case ($urandom_range(4))
                    0: pos = $urandom;
                    1: pos = $urandom_range(400, 1);
                    2: pos = 32'hFFFF_FFFF - $urandom_range(40, 0);
                    3: begin
                        first_pos = 64'd1;
                        width = 64'd1;
                        repeat ($urandom_range(32, 1)) begin
                            first_pos = first_pos + width;
                            width = width * eff;
                            if (width > 64'h1_0000_0000) begin
                                width = 64'h1_0000_0000;
                            end
                        end
                        first_pos = first_pos + $urandom_range(2, 0) - 64'd1;
                        pos = (first_pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : first_pos[31:0];
                    end
                    default: pos = $urandom_range(1) ? 32'd0 : (32'd1 << $urandom_range(31));
                endcase
                send_request(MODE_LOAD, pos);
                sent++;
                upward = $urandom_range(1);
                steps = $urandom_range(10, 1);
                repeat (steps) begin
                    pick = $urandom_range(9);
                    if (pick < 6) begin
                        send_request(upward ? MODE_INC : MODE_DEC, $urandom);
                    end else if (pick < 9) begin
                        send_request(upward ? MODE_DEC : MODE_INC, $urandom);
                    end else begin
                        send_request(MODE_QUERY, $urandom);
                    end
                    sent++;
                end
            end else begin
                send_request(t_mode'($urandom_range(3)), $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_request(MODE_QUERY, 32'h0000_0000);
        send_request(MODE_DEC,   32'hFFFF_FFFF);
        send_request(MODE_INC,   32'h0000_0000);
        send_request(MODE_INC,   32'hFFFF_FFFF);
        send_request(MODE_INC,   32'h0000_0000);
        send_request(MODE_DEC,   32'hFFFF_FFFF);
        send_request(MODE_LOAD,  32'h0000_0000);
        send_request(MODE_LOAD,  32'h0000_0001);
        send_request(MODE_LOAD,  32'hFFFF_FFFF);
        send_request(MODE_INC,   32'h0000_0000);
        send_request(MODE_INC,   32'h0000_0000);
        send_request(MODE_QUERY, 32'hFFFF_FFFF);
        send_request(MODE_DEC,   32'h0000_0000);
        send_request(MODE_LOAD,  32'h8000_0000);
        send_request(MODE_LOAD,  32'h5555_5555);
        send_request(MODE_LOAD,  32'hAAAA_AAAA);
        send_request(MODE_LOAD,  32'h0000_0007);
        send_request(MODE_INC,   32'h0000_0000);
        send_request(MODE_DEC,   32'h0000_0000);
        send_request(MODE_DEC,   32'h0000_0000);
        send_request(MODE_LOAD,  32'h0000_0002);
        send_request(MODE_DEC,   32'h0000_0000);
        send_request(MODE_LOAD,  32'hFFFF_FFFE);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            i_cfg_we = 1'b1;
            i_cfg_data = FANOUT_BITS'(fanout_plan[ph]);
            fanout_now = fanout_plan[ph];
            @(negedge i_clk);
            i_cfg_we = 1'b0;
            case (ph % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 56; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 56; end
                default: begin sender_idle_pct = 20; stall_pct = 20; end
            endcase
            send_request(MODE_INC, $urandom);
            send_request(MODE_QUERY, $urandom);
            send_request(MODE_DEC, $urandom);
            walk_tree(240);
        end
        settle();

        $display("Run covered %0d requests and %0d checked results over 9 fanout settings,",
                 requests_sent, o_results);
        $display("with loads, steps across layer ends, root and end-of-tree holds and stalls.");
        if (o_mismatches == 0 && o_pending == 0) begin
            $display("kary_tree_position_tracker verification clean");
        end else begin
            $display("kary_tree_position_tracker verification failed");
        end
        $finish;
    end

endmodule
